/* sv/rpw_pkg.sv */
// ----------------------------------------------------------------------------
// Relay pulse and input watch timer package
// Shared widths, reload constants, opcodes and register indexes.
// ----------------------------------------------------------------------------
package rpw_pkg;

  localparam int RELAY_COUNT_DEF = 5;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 3;
  localparam int ARG_W   = 16;
  localparam int INP_W   = 5;
  localparam int LEVEL_W = 5;
  localparam int WD_W    = 16;
  localparam int DB_W    = 8;
  localparam int TENTH_W = 4;
  localparam int HALF_W  = 3;
  localparam int SEC_W   = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [TENTH_W-1:0] TENTH_RELOAD = 4'd12;
  localparam logic [TENTH_W-1:0] TENTH_RESET  = 4'd5;
  localparam logic [HALF_W-1:0]  HALF_RELOAD  = 3'd5;
  localparam logic [SEC_W-1:0]   SEC_RELOAD   = 2'd2;

  localparam logic [WD_W-1:0] WD_RELOAD_RESET = 16'd600;
  localparam logic [DB_W-1:0] DB_TICKS_RESET  = 8'd5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_PULSE  = 3'd1,
    OP_SET    = 3'd2,
    OP_WD_LD  = 3'd3,
    OP_SAMPLE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_WD_RELOAD = 2'd0,
    REG_WD_ENABLE = 2'd1,
    REG_DB_TICKS  = 2'd2
  } cfg_reg_t;

endpackage

/* sv/rpw_if.sv */
// ----------------------------------------------------------------------------
// Relay pulse and input watch timer channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rpw_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpw_pkg::OP_W-1:0]      opcode;
  logic [rpw_pkg::IDX_W-1:0]     relay_index;
  logic [rpw_pkg::ARG_W-1:0]     argument;
  logic [rpw_pkg::INP_W-1:0]     input_bits;

  modport source (output valid, output opcode, output relay_index, output argument,
                  output input_bits, input ready);
  modport sink (input valid, input opcode, input relay_index, input argument,
                input input_bits, output ready);
endinterface

interface rpw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rpw_pkg::LEVEL_W-1:0]   relay_levels;
  logic                          module_reset;
  logic                          led_level;
  logic                          report_valid;
  logic [rpw_pkg::INP_W-1:0]     report_inputs;

  modport source (output valid, output relay_levels, output module_reset,
                  output led_level, output report_valid, output report_inputs,
                  input ready);
  modport sink (input valid, input relay_levels, input module_reset, input led_level,
                input report_valid, input report_inputs, output ready);
endinterface

/* sv/relay_pulse_and_input_watch_timer.sv */
// ----------------------------------------------------------------------------
// Relay pulse and input watch timer
// Relay pulse timers, link watchdog, heartbeat LED and debounced input watch.
// ----------------------------------------------------------------------------
// Each command word passes an input register and is then applied to the
// timer state, landing in a result register, so the block takes one word
// per clock while results are taken; each result is offered from the result
// register. While a finished result waits on the output, one more command
// is taken into the input register and the input then stalls until the
// result is taken. Configuration is on an APB-style port at byte addresses
// 0, 4 and 8 and takes effect on the next command.
module relay_pulse_and_input_watch_timer #(
  parameter int RELAY_COUNT = rpw_pkg::RELAY_COUNT_DEF,
  parameter int COUNT_WIDTH = rpw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rpw_in_if.sink                          in_word,
  rpw_out_if.source                       out_word,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rpw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rpw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int LVL_EXT_W = (RELAY_COUNT > rpw_pkg::LEVEL_W) ? RELAY_COUNT
                                                              : rpw_pkg::LEVEL_W;

  logic [rpw_pkg::WD_W-1:0] wd_reload_r;
  logic                     wd_enable_r;
  logic [rpw_pkg::DB_W-1:0] db_ticks_r;
  logic                     cfg_wr;
  rpw_pkg::cfg_reg_t        cfg_sel;

  logic                        s1_v_r;
  logic [rpw_pkg::OP_W-1:0]    s1_op_r;
  logic [rpw_pkg::IDX_W-1:0]   s1_idx_r;
  logic [rpw_pkg::ARG_W-1:0]   s1_arg_r;
  logic [rpw_pkg::INP_W-1:0]   s1_inp_r;
  logic                        adv;
  logic                        in_acc;

  logic [COUNT_WIDTH-1:0]      rc_r   [RELAY_COUNT];
  logic [COUNT_WIDTH-1:0]      rc_nxt [RELAY_COUNT];
  logic [RELAY_COUNT-1:0]      rly_armed_r, rly_armed_nxt;
  logic [RELAY_COUNT-1:0]      rly_drive_r, rly_drive_nxt;
  logic [rpw_pkg::WD_W-1:0]    wd_count_r, wd_count_nxt;
  logic [rpw_pkg::DB_W-1:0]    db_count_r, db_count_nxt;
  logic                        db_armed_r, db_armed_nxt;
  logic                        db_done_r, db_done_nxt;
  logic                        waiting_r, waiting_nxt;
  logic [rpw_pkg::INP_W-1:0]   stored_r, stored_nxt;
  logic [rpw_pkg::TENTH_W-1:0] tenth_r, tenth_nxt;
  logic [rpw_pkg::HALF_W-1:0]  half_r, half_nxt;
  logic [rpw_pkg::SEC_W-1:0]   sec_r, sec_nxt;
  logic                        led_r, led_nxt;
  logic                        fired;
  logic                        report;
  logic [rpw_pkg::INP_W-1:0]   reported;
  logic [LVL_EXT_W-1:0]        lvl_ext;

  logic                        out_v_r;
  logic [rpw_pkg::LEVEL_W-1:0] out_levels_r;
  logic                        out_mreset_r;
  logic                        out_led_r;
  logic                        out_rep_v_r;
  logic [rpw_pkg::INP_W-1:0]   out_rep_r;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_sel = rpw_pkg::cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_reload_r <= rpw_pkg::WD_RELOAD_RESET;
      wd_enable_r <= 1'b1;
      db_ticks_r  <= rpw_pkg::DB_TICKS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        rpw_pkg::REG_WD_RELOAD: wd_reload_r <= pwdata[rpw_pkg::WD_W-1:0];
        rpw_pkg::REG_WD_ENABLE: wd_enable_r <= pwdata[0];
        rpw_pkg::REG_DB_TICKS:  db_ticks_r  <= pwdata[rpw_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      rpw_pkg::REG_WD_RELOAD: prdata = rpw_pkg::CFG_DATA_W'(wd_reload_r);
      rpw_pkg::REG_WD_ENABLE: prdata = rpw_pkg::CFG_DATA_W'(wd_enable_r);
      rpw_pkg::REG_DB_TICKS:  prdata = rpw_pkg::CFG_DATA_W'(db_ticks_r);
      default:                prdata = '0;
    endcase
  end

  // Handshake: the input register drains into the result register.
  assign adv           = s1_v_r && (!out_v_r || out_word.ready);
  assign in_word.ready = !s1_v_r || adv;
  assign in_acc        = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_word.opcode;
      s1_idx_r <= in_word.relay_index;
      s1_arg_r <= in_word.argument;
      s1_inp_r <= in_word.input_bits;
    end
  end

  // Next state for one command word.
  always_comb begin
    rc_nxt        = rc_r;
    rly_armed_nxt = rly_armed_r;
    rly_drive_nxt = rly_drive_r;
    wd_count_nxt  = wd_count_r;
    db_count_nxt  = db_count_r;
    db_armed_nxt  = db_armed_r;
    db_done_nxt   = db_done_r;
    waiting_nxt   = waiting_r;
    stored_nxt    = stored_r;
    tenth_nxt     = tenth_r;
    half_nxt      = half_r;
    sec_nxt       = sec_r;
    led_nxt       = led_r;
    fired         = 1'b0;
    report        = 1'b0;
    reported      = '0;
    unique case (rpw_pkg::op_t'(s1_op_r))
      rpw_pkg::OP_TICK: begin
        db_count_nxt = db_count_r - 1'b1;
        if (db_count_nxt == '0 && db_armed_r) begin
          db_done_nxt  = 1'b1;
          db_armed_nxt = 1'b0;
        end
        tenth_nxt = tenth_r - 1'b1;
        if (tenth_nxt == '0) begin
          tenth_nxt = rpw_pkg::TENTH_RELOAD;
          for (int i = 0; i < RELAY_COUNT; i++) begin
            rc_nxt[i] = rc_r[i] - 1'b1;
            if (rc_nxt[i] == '0 && rly_armed_r[i]) begin
              rly_drive_nxt[i] = 1'b0;
              rly_armed_nxt[i] = 1'b0;
            end
          end
          wd_count_nxt = wd_count_r - 1'b1;
          if (wd_count_nxt == '0 && wd_enable_r) begin
            fired        = 1'b1;
            wd_count_nxt = wd_reload_r;
          end
          half_nxt = half_r - 1'b1;
          if (half_nxt == '0) begin
            half_nxt = rpw_pkg::HALF_RELOAD;
            sec_nxt  = sec_r - 1'b1;
            if (sec_nxt == '0) begin
              sec_nxt = rpw_pkg::SEC_RELOAD;
              led_nxt = !led_r;
            end
          end
        end
      end
      rpw_pkg::OP_PULSE: begin
        for (int i = 0; i < RELAY_COUNT; i++) begin
          if (int'(s1_idx_r) == i + 1) begin
            rly_drive_nxt[i] = 1'b1;
            rly_armed_nxt[i] = 1'b1;
            rc_nxt[i]        = COUNT_WIDTH'(s1_arg_r);
          end
        end
      end
      rpw_pkg::OP_SET: begin
        for (int i = 0; i < RELAY_COUNT; i++) begin
          if (int'(s1_idx_r) == i + 1) begin
            rly_drive_nxt[i] = s1_arg_r[0];
          end
        end
      end
      rpw_pkg::OP_WD_LD: begin
        wd_count_nxt = s1_arg_r;
      end
      rpw_pkg::OP_SAMPLE: begin
        if (!waiting_r) begin
          if (stored_r != s1_inp_r) begin
            db_count_nxt = db_ticks_r;
            db_armed_nxt = 1'b1;
            db_done_nxt  = 1'b0;
            waiting_nxt  = 1'b1;
          end
        end else if (db_done_r) begin
          db_done_nxt = 1'b0;
          waiting_nxt = 1'b0;
          if (stored_r != s1_inp_r) begin
            stored_nxt = s1_inp_r;
            report     = 1'b1;
            reported   = s1_inp_r;
          end
        end
      end
      default: ;
    endcase
    lvl_ext = LVL_EXT_W'(rly_drive_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RELAY_COUNT; i++) begin
        rc_r[i] <= '0;
      end
      rly_armed_r <= '0;
      rly_drive_r <= '0;
      wd_count_r  <= rpw_pkg::WD_RELOAD_RESET;
      db_count_r  <= '0;
      db_armed_r  <= 1'b0;
      db_done_r   <= 1'b0;
      waiting_r   <= 1'b0;
      stored_r    <= '0;
      tenth_r     <= rpw_pkg::TENTH_RESET;
      half_r      <= rpw_pkg::HALF_RELOAD;
      sec_r       <= rpw_pkg::SEC_RELOAD;
      led_r       <= 1'b0;
    end else if (adv) begin
      rc_r        <= rc_nxt;
      rly_armed_r <= rly_armed_nxt;
      rly_drive_r <= rly_drive_nxt;
      wd_count_r  <= wd_count_nxt;
      db_count_r  <= db_count_nxt;
      db_armed_r  <= db_armed_nxt;
      db_done_r   <= db_done_nxt;
      waiting_r   <= waiting_nxt;
      stored_r    <= stored_nxt;
      tenth_r     <= tenth_nxt;
      half_r      <= half_nxt;
      sec_r       <= sec_nxt;
      led_r       <= led_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_levels_r <= lvl_ext[rpw_pkg::LEVEL_W-1:0];
      out_mreset_r <= fired;
      out_led_r    <= led_nxt;
      out_rep_v_r  <= report;
      out_rep_r    <= reported;
    end
  end

  assign out_word.valid         = out_v_r;
  assign out_word.relay_levels  = out_levels_r;
  assign out_word.module_reset  = out_mreset_r;
  assign out_word.led_level     = out_led_r;
  assign out_word.report_valid  = out_rep_v_r;
  assign out_word.report_inputs = out_rep_r;

`ifndef SYNTH
  a_idle_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    !waiting_r |-> (!db_done_r && !db_armed_r))
    else $error("debounce armed or done outside the waiting state");

  a_wd_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fired) |=> (wd_count_r == $past(wd_reload_r)))
    else $error("watchdog not reloaded after expiry");

  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fired) |-> wd_enable_r)
    else $error("watchdog fired while disabled");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("advanced word did not reach the result register");

  a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !report) |=> (out_rep_r == '0))
    else $error("report inputs nonzero without a report");
`endif

endmodule
